[hw/rtl/uart_sensor_host_message_receiver_macros.svh]
// Assertion macros used by the checker file of the host message receiver.
// No dependencies; include by bare file name.
`ifndef UART_SENSOR_HOST_MESSAGE_RECEIVER_MACROS_SVH
`define UART_SENSOR_HOST_MESSAGE_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define USHMR_ASSERT_NOW(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("host message receiver: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define USHMR_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("host message receiver: next-cycle check failed");

`endif

[hw/rtl/ushmr_pkg.sv]
// Types, protocol codes and sizes for the host message receiver.
// No dependencies; compile first.
`timescale 1ns / 1ps

package ushmr_pkg;

  localparam int PAYLOAD_MAX_DEF = 32;

  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  mode_t;
  typedef logic [1:0]  cfg_index_t;
  typedef logic [31:0] cfg_data_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_REPLY   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_RESET   = 2'd3
  } kind_t;

  // Register indexes
  localparam cfg_index_t CFG_MODE_COUNT    = 2'd0;
  localparam cfg_index_t CFG_CALLBACK_MASK = 2'd1;
  localparam cfg_index_t CFG_HEARTBEAT     = 2'd2;

  // Register reset values
  localparam logic [3:0] MODE_COUNT_RST     = 4'd1;
  localparam byte_t      CALLBACK_MASK_RST  = 8'h00;
  localparam cfg_data_t  HEARTBEAT_RST      = 32'd1000;

  // Link protocol bytes
  localparam byte_t NACK_CODE   = 8'h02;
  localparam byte_t SELECT_CODE = 8'h43;
  localparam byte_t WRITE_CODE  = 8'h44;
  localparam byte_t EXT_CODE    = 8'h46;
  localparam byte_t EXT_MARK    = 8'hB9;
  localparam byte_t CHECK_SEED  = 8'hFF;

endpackage

[hw/rtl/ushmr_channels.sv]
// Valid/ready channel interfaces of the host message receiver.
// Depends on ushmr_pkg.
`timescale 1ns / 1ps

interface ushmr_in_if;
  import ushmr_pkg::*;
  logic  valid;
  logic  ready;
  logic  command;
  byte_t rx_byte;
  modport source  (output valid, command, rx_byte, input ready);
  modport sink    (input valid, command, rx_byte, output ready);
  modport monitor (input valid, ready, command, rx_byte);
endinterface

interface ushmr_out_if;
  import ushmr_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  byte_t data_byte;
  mode_t payload_mode;
  logic  last;
  mode_t active_mode;
  modport source  (output valid, kind, data_byte, payload_mode, last, active_mode,
                   input ready);
  modport sink    (input valid, kind, data_byte, payload_mode, last, active_mode,
                   output ready);
  modport monitor (input valid, ready, kind, data_byte, payload_mode, last, active_mode);
endinterface

interface ushmr_cfg_if;
  import ushmr_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/ushmr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ushmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/ushmr_heartbeat.sv]
// Saturating tick counter that flags a missing NACK from the host.
// Depends on ushmr_pkg.
`timescale 1ns / 1ps

module ushmr_heartbeat (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick,
  input  logic                clear,
  input  ushmr_pkg::cfg_data_t limit,
  output logic                expire
);
  import ushmr_pkg::*;

  cfg_data_t count;
  cfg_data_t count_next;

  // Advance with saturation, compare against the limit
  assign count_next = (count == '1) ? count : count + 32'd1;
  assign expire     = tick && (count_next > limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clear || expire) begin
      count <= '0;
    end else if (tick) begin
      count <= count_next;
    end
  end

endmodule

[hw/rtl/uart_sensor_host_message_receiver.sv]
// Top level of the sensor-side host message receiver: frame parser, reply and
// payload sequencer, configuration registers. Depends on ushmr_pkg,
// ushmr_channels, ushmr_ram and ushmr_heartbeat.
//
//   channel  dir  words
//   host     in   command (tick or byte), rx_byte
//   result   out  kind, data_byte, payload_mode, last, active_mode
//   cfg      in   index, data (register writes, always ready)
//
// A byte or tick that yields no result leaves host ready for the next word. A
// word that yields results is accepted, then its reply words go out one per
// cycle while result is ready; payload bytes are read back from the payload RAM
// one at a time, each through an address state and then a read-data state. Host
// is not ready while the results of a word are still being issued. Reset is
// synchronous; the payload RAM needs no clearing pass, since only entries written
// in the current frame are read. A stall on result holds the sequencer in place.
`timescale 1ns / 1ps

module uart_sensor_host_message_receiver #(
  parameter int PAYLOAD_MAX = ushmr_pkg::PAYLOAD_MAX_DEF
) (
  input logic        clk,
  input logic        rst,
  ushmr_in_if.sink   host,
  ushmr_out_if.source result,
  ushmr_cfg_if.sink  cfg
);
  import ushmr_pkg::*;

  localparam int AW = $clog2(PAYLOAD_MAX);
  localparam logic [1:0] REPLY_LAST = 2'd2;

  typedef enum logic [3:0] {
    P_IDLE, P_SEL_MODE, P_SEL_CHECK, P_EXT_ZERO, P_EXT_SKIP,
    P_EXT_B9, P_EXT_HEAD, P_EXT_DATA, P_EXT_CHECK
  } parse_t;

  typedef enum logic [2:0] {
    C_IN, C_ONE, C_REPLY, C_RD, C_DATA
  } ctl_t;

  // Configuration registers
  logic [3:0] mode_count;
  byte_t      callback_mask;
  cfg_data_t  heartbeat_ticks;

  // Parser state
  parse_t parse;
  ctl_t   ctl;
  byte_t  running_check;
  byte_t  frame_header;
  byte_t  pending_select;
  byte_t  byte_index;
  mode_t  selected_mode;

  // Sequencer state
  kind_t      one_kind;
  mode_t      one_pmode;
  logic [1:0] reply_idx;
  byte_t      emit_idx;

  // Output register
  logic  out_valid;
  kind_t out_kind;
  byte_t out_data;
  mode_t out_pmode;
  logic  out_last;
  mode_t out_amode;

  logic  host_take, byte_take, tick_take, slot_free, out_load;
  logic  hb_clear, hb_expire;
  byte_t rx, frame_size, index_inc, emit_final, reply_c0, reply_data;
  logic  oversize, deliver, check_ok, sel_valid;
  logic  ram_we, ram_re;
  byte_t ram_rdata;

  // Handshake decode
  assign host.ready = (ctl == C_IN);
  assign cfg.ready  = 1'b1;
  assign host_take  = host.valid && host.ready;
  assign byte_take  = host_take && !host.command;
  assign tick_take  = host_take && host.command;
  assign slot_free  = !out_valid || result.ready;
  assign out_load   = slot_free && (ctl == C_ONE || ctl == C_REPLY || ctl == C_DATA);
  assign rx         = host.rx_byte;

  // Frame arithmetic
  assign frame_size = byte_t'(1) << frame_header[5:3];
  assign index_inc  = byte_index + byte_t'(1);
  assign emit_final = frame_size - byte_t'(1);
  assign oversize   = frame_size > byte_t'(PAYLOAD_MAX);
  assign deliver    = (frame_header[7:6] != 2'b00) && callback_mask[frame_header[2:0]];
  assign check_ok   = (rx == running_check);
  assign sel_valid  = (pending_select < {4'd0, mode_count}) && (pending_select[7:3] == 5'd0);
  assign reply_c0   = WRITE_CODE | {5'd0, selected_mode};

  always_comb begin
    unique case (reply_idx)
      2'd0:    reply_data = reply_c0;
      2'd1:    reply_data = '0;
      default: reply_data = CHECK_SEED ^ reply_c0;
    endcase
  end

  // Heartbeat counter
  assign hb_clear = byte_take && (parse == P_IDLE) && (rx == NACK_CODE);

  ushmr_heartbeat u_heartbeat (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_take),
    .clear  (hb_clear),
    .limit  (heartbeat_ticks),
    .expire (hb_expire)
  );

  // Payload store: written while the frame streams in, read back on delivery
  assign ram_we = byte_take && (parse == P_EXT_DATA) && (byte_index < byte_t'(PAYLOAD_MAX));
  assign ram_re = (ctl == C_RD);

  ushmr_ram #(
    .WIDTH ($bits(byte_t)),
    .DEPTH (PAYLOAD_MAX)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_index[AW-1:0]),
    .wdata (rx),
    .re    (ram_re),
    .raddr (emit_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Parser, sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_count      <= MODE_COUNT_RST;
      callback_mask   <= CALLBACK_MASK_RST;
      heartbeat_ticks <= HEARTBEAT_RST;
      parse           <= P_IDLE;
      ctl             <= C_IN;
      selected_mode   <= '0;
      out_valid       <= 1'b0;
    end else begin
      // Register writes
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_MODE_COUNT:    mode_count      <= cfg.data[3:0];
          CFG_CALLBACK_MASK: callback_mask   <= cfg.data[7:0];
          CFG_HEARTBEAT:     heartbeat_ticks <= cfg.data;
          default: ;
        endcase
      end

      // Drop the output word once taken, unless a new one replaces it
      if (out_valid && result.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (ctl)
        C_IN: begin
          if (tick_take && hb_expire) begin
            parse     <= P_IDLE;
            one_kind  <= KIND_RESET;
            one_pmode <= '0;
            ctl       <= C_ONE;
          end else if (byte_take) begin
            unique case (parse)
              P_SEL_MODE: begin
                pending_select <= rx;
                running_check  <= CHECK_SEED ^ SELECT_CODE ^ rx;
                parse          <= P_SEL_CHECK;
              end
              P_SEL_CHECK: begin
                if (check_ok && sel_valid) begin
                  selected_mode <= pending_select[2:0];
                end
                parse <= P_IDLE;
              end
              P_EXT_ZERO: parse <= (rx == '0) ? P_EXT_B9 : P_EXT_SKIP;
              P_EXT_SKIP: parse <= P_IDLE;
              P_EXT_B9:   parse <= (rx == EXT_MARK) ? P_EXT_HEAD : P_IDLE;
              P_EXT_HEAD: begin
                frame_header  <= rx;
                running_check <= CHECK_SEED ^ rx;
                byte_index    <= '0;
                parse         <= P_EXT_DATA;
              end
              P_EXT_DATA: begin
                running_check <= running_check ^ rx;
                byte_index    <= index_inc;
                if (index_inc >= frame_size) begin
                  parse <= P_EXT_CHECK;
                end
              end
              P_EXT_CHECK: begin
                parse <= P_IDLE;
                if (oversize || !check_ok) begin
                  one_kind  <= KIND_ERROR;
                  one_pmode <= frame_header[2:0];
                  ctl       <= C_ONE;
                end else if (deliver) begin
                  emit_idx <= '0;
                  ctl      <= C_RD;
                end
              end
              // Between frames: commands start here, other bytes are ignored
              default: begin
                if (rx == NACK_CODE) begin
                  parse     <= P_IDLE;
                  reply_idx <= '0;
                  ctl       <= C_REPLY;
                end else if (rx == SELECT_CODE) begin
                  parse <= P_SEL_MODE;
                end else if (rx == EXT_CODE) begin
                  parse <= P_EXT_ZERO;
                end else begin
                  parse <= P_IDLE;
                end
              end
            endcase
          end
        end

        // Single error or reset-request word
        C_ONE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= one_kind;
            out_data  <= '0;
            out_pmode <= one_pmode;
            out_last  <= 1'b1;
            out_amode <= selected_mode;
            ctl       <= C_IN;
          end
        end

        // Three-byte write frame answering a NACK
        C_REPLY: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_REPLY;
            out_data  <= reply_data;
            out_pmode <= '0;
            out_last  <= (reply_idx == REPLY_LAST);
            out_amode <= selected_mode;
            reply_idx <= reply_idx + 2'd1;
            if (reply_idx == REPLY_LAST) begin
              ctl <= C_IN;
            end
          end
        end

        // Address cycle of a payload read
        C_RD: ctl <= C_DATA;

        // Read data ready: hand it out when the output slot frees
        C_DATA: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_PAYLOAD;
            out_data  <= ram_rdata;
            out_pmode <= frame_header[2:0];
            out_last  <= (emit_idx == emit_final);
            out_amode <= selected_mode;
            if (emit_idx == emit_final) begin
              ctl <= C_IN;
            end else begin
              emit_idx <= emit_idx + byte_t'(1);
              ctl      <= C_RD;
            end
          end
        end

        default: ctl <= C_IN;
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.kind         = out_kind;
  assign result.data_byte    = out_data;
  assign result.payload_mode = out_pmode;
  assign result.last         = out_last;
  assign result.active_mode  = out_amode;

endmodule

[hw/rtl/ushmr_checker.sv]
// Port-level checks on the host message receiver, bound to its top level.
// Depends on ushmr_pkg, ushmr_channels and the assertion macros.
`timescale 1ns / 1ps
`include "uart_sensor_host_message_receiver_macros.svh"

module ushmr_checker (
  input logic             clk,
  input logic             rst,
  input logic             host_ready,
  input logic             res_valid,
  input logic             res_ready,
  input ushmr_pkg::kind_t res_kind,
  input ushmr_pkg::byte_t res_data,
  input ushmr_pkg::mode_t res_pmode,
  input logic             res_last,
  input ushmr_pkg::mode_t res_amode
);
  import ushmr_pkg::*;

  logic        lone_kind;
  logic        mid_take;
  logic        res_stall;
  logic [16:0] res_word;

  assign lone_kind = (res_kind == KIND_ERROR) || (res_kind == KIND_RESET);
  assign mid_take  = res_valid && res_ready && !res_last;
  assign res_stall = res_valid && !res_ready;
  assign res_word  = {res_kind, res_data, res_pmode, res_last, res_amode};

  // No new word is taken while a result sequence is still open
  `USHMR_ASSERT_NOW(a_no_take_mid_sequence, clk, rst, res_valid && !res_last, !host_ready)

  // Error and reset-request words stand alone
  `USHMR_ASSERT_NOW(a_single_word_kinds, clk, rst, res_valid && lone_kind, res_last)

  // Active mode cannot move inside one result sequence
  `USHMR_ASSERT_NEXT(a_mode_steady, clk, rst, mid_take, $stable(res_amode))

  // Stalled result word holds
  `USHMR_ASSERT_NEXT(a_stall_hold, clk, rst, res_stall, res_valid && $stable(res_word))

endmodule

bind uart_sensor_host_message_receiver ushmr_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .host_ready (host.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_kind   (result.kind),
  .res_data   (result.data_byte),
  .res_pmode  (result.payload_mode),
  .res_last   (result.last),
  .res_amode  (result.active_mode)
);

[tb/uart_sensor_host_message_receiver_tb.sv]
// Self-checking testbench for the sensor-side host message receiver.
// Depends on ushmr_pkg, the ushmr channel interfaces and the receiver RTL.
// A typed table covers the directed cases; random host traffic is checked against the predictor.
`timescale 1ns / 1ps

module uart_sensor_host_message_receiver_tb;
  import ushmr_pkg::*;

  localparam int PAYLOAD_MAX = PAYLOAD_MAX_DEF;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 10;
  localparam int PHASE_WORDS = 8;
  localparam int NUM_PHASES  = 6;

  typedef enum logic [3:0] {
    PS_IDLE, PS_SEL_MODE, PS_SEL_CHECK, PS_EXT_ZERO, PS_EXT_SKIP,
    PS_EXT_B9, PS_EXT_HEAD, PS_EXT_DATA, PS_EXT_CHECK
  } parse_state_t;

  typedef struct packed {
    kind_t kind;
    byte_t data;
    mode_t pmode;
    logic  last;
    mode_t amode;
  } host_result_t;

  // One line of the directed script: a register setting or a host word,
  // with its results typed in where they are obvious
  typedef struct packed {
    logic       is_cfg;
    logic [3:0] mc;
    byte_t      mask;
    cfg_data_t  hb;
    logic       cmd;
    byte_t      b;
    logic       typed;
    logic [1:0] n;
    kind_t      kind;
    byte_t      d0;
    byte_t      d1;
    byte_t      d2;
    mode_t      pmode;
    mode_t      amode;
  } script_row_t;

  logic clk;
  logic rst;

  ushmr_in_if  host_ch ();
  ushmr_out_if res_ch ();
  ushmr_cfg_if cfg_ch ();

  uart_sensor_host_message_receiver dut (
    .clk    (clk),
    .rst    (rst),
    .host   (host_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Predictor copy of the registers and parser state
  logic [3:0]   mode_count_r = MODE_COUNT_RST;
  byte_t        cb_mask_r    = CALLBACK_MASK_RST;
  cfg_data_t    hb_limit_r   = HEARTBEAT_RST;
  parse_state_t pstate       = PS_IDLE;
  byte_t        run_chk      = CHECK_SEED;
  byte_t        hdr_r        = '0;
  byte_t        sel_pending  = '0;
  int unsigned  fill         = 0;
  byte_t        payload_r [PAYLOAD_MAX];
  mode_t        sel_mode_r   = '0;
  logic [31:0]  ticks_r      = '0;

  host_result_t step_results [$];
  host_result_t due_results [$];
  script_row_t  script [$];

  int  send_idle_pct = 24;
  int  recv_idle_pct = 54;
  bit  hold_req      = 1'b0;
  int  mismatches    = 0;
  int  words_sent    = 0;
  int  results_seen  = 0;
  int  cfg_writes    = 0;
  int  kind_seen [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic void emit(input kind_t k, input byte_t d, input mode_t pm);
    host_result_t r;
    r.kind  = k;
    r.data  = d;
    r.pmode = pm;
    r.last  = 1'b0;
    r.amode = '0;
    step_results.push_back(r);
  endfunction

  // Advance the parser by one host word; results land in step_results
  function automatic void parse_host_word(input logic cmd, input byte_t b);
    int unsigned frame_len;
    byte_t c0;
    step_results.delete();
    frame_len = 32'd1 << hdr_r[5:3];
    if (cmd) begin
      // heartbeat: saturating tick count, reset request when it passes the limit
      if (ticks_r != '1) ticks_r = ticks_r + 32'd1;
      if (ticks_r > hb_limit_r) begin
        emit(KIND_RESET, 8'h00, 3'd0);
        ticks_r = '0;
        pstate  = PS_IDLE;
      end
    end else begin
      case (pstate)
        PS_SEL_MODE: begin
          sel_pending = b;
          run_chk     = CHECK_SEED ^ SELECT_CODE ^ b;
          pstate      = PS_SEL_CHECK;
        end
        PS_SEL_CHECK: begin
          if (b == run_chk && sel_pending < {4'd0, mode_count_r} && sel_pending < 8'd8)
            sel_mode_r = sel_pending[2:0];
          pstate = PS_IDLE;
        end
        PS_EXT_ZERO: pstate = (b == 8'h00) ? PS_EXT_B9 : PS_EXT_SKIP;
        PS_EXT_SKIP: pstate = PS_IDLE;
        PS_EXT_B9:   pstate = (b == EXT_MARK) ? PS_EXT_HEAD : PS_IDLE;
        PS_EXT_HEAD: begin
          hdr_r   = b;
          run_chk = CHECK_SEED ^ b;
          fill    = 0;
          pstate  = PS_EXT_DATA;
        end
        PS_EXT_DATA: begin
          if (fill < PAYLOAD_MAX) payload_r[fill] = b;
          run_chk = run_chk ^ b;
          fill++;
          if (fill >= frame_len) pstate = PS_EXT_CHECK;
        end
        PS_EXT_CHECK: begin
          pstate = PS_IDLE;
          if (frame_len > PAYLOAD_MAX || b != run_chk) begin
            emit(KIND_ERROR, 8'h00, hdr_r[2:0]);
          end else if (hdr_r[7:6] != 2'b00 && cb_mask_r[hdr_r[2:0]]) begin
            for (int i = 0; i < int'(frame_len); i++)
              emit(KIND_PAYLOAD, payload_r[i], hdr_r[2:0]);
          end
        end
        default: begin
          // between frames: NACK answers with a write frame, select and extended codes open frames
          pstate = PS_IDLE;
          if (b == NACK_CODE) begin
            c0 = WRITE_CODE | {5'd0, sel_mode_r};
            emit(KIND_REPLY, c0, 3'd0);
            emit(KIND_REPLY, 8'h00, 3'd0);
            emit(KIND_REPLY, CHECK_SEED ^ c0, 3'd0);
            ticks_r = '0;
          end else if (b == SELECT_CODE) begin
            pstate = PS_SEL_MODE;
          end else if (b == EXT_CODE) begin
            pstate = PS_EXT_ZERO;
          end
        end
      endcase
    end
    foreach (step_results[k]) begin
      step_results[k].last  = (k == step_results.size() - 1);
      step_results[k].amode = sel_mode_r;
    end
  endfunction

  function automatic void row_pred(input logic cmd, input byte_t b);
    script_row_t r;
    r     = '0;
    r.cmd = cmd;
    r.b   = b;
    script.push_back(r);
  endfunction

  function automatic void row_typed(input logic cmd, input byte_t b, input logic [1:0] n,
                                    input kind_t k, input byte_t d0, input byte_t d1,
                                    input byte_t d2, input mode_t pm, input mode_t am);
    script_row_t r;
    r       = '0;
    r.cmd   = cmd;
    r.b     = b;
    r.typed = 1'b1;
    r.n     = n;
    r.kind  = k;
    r.d0    = d0;
    r.d1    = d1;
    r.d2    = d2;
    r.pmode = pm;
    r.amode = am;
    script.push_back(r);
  endfunction

  // Offer one host word, hold it until accepted, then advance the predictor
  task automatic send_word(input logic cmd, input byte_t b, input bit predicted = 1'b1);
    while ($urandom_range(99) < send_idle_pct) begin
      host_ch.valid <= 1'b0;
      @(posedge clk);
    end
    host_ch.valid   <= 1'b1;
    host_ch.command <= cmd;
    host_ch.rx_byte <= b;
    do @(posedge clk); while (!host_ch.ready);
    parse_host_word(cmd, b);
    if (predicted) foreach (step_results[k]) due_results.push_back(step_results[k]);
    words_sent++;
  endtask

  // Drop valid and wait until every owed result is in and the block has settled
  task automatic drain();
    host_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [3:0] mc, input byte_t mask, input cfg_data_t hb);
    cfg_index_t idxs [3];
    cfg_data_t  vals [3];
    idxs = '{CFG_MODE_COUNT, CFG_CALLBACK_MASK, CFG_HEARTBEAT};
    vals = '{{28'd0, mc}, {24'd0, mask}, hb};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idxs[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    mode_count_r = mc;
    cb_mask_r    = mask;
    hb_limit_r   = hb;
    cfg_writes++;
  endtask

  // One random host message: mostly well-formed frames, some noise
  task automatic send_host_message();
    int          pick;
    int unsigned frame_len;
    byte_t       m;
    byte_t       hdr;
    byte_t       chk;
    byte_t       d;
    pick = $urandom_range(99);
    if (pick < 22) begin
      send_word(1'b0, NACK_CODE);
    end else if (pick < 42) begin
      // select: mostly near the valid range, mostly with a good checksum
      if ($urandom_range(9) < 7) m = 8'($urandom_range(9));
      else m = 8'($urandom_range(255));
      chk = CHECK_SEED ^ SELECT_CODE ^ m;
      if ($urandom_range(9) == 0) chk = chk ^ 8'($urandom_range(255, 1));
      send_word(1'b0, SELECT_CODE);
      send_word(1'b0, m);
      send_word(1'b0, chk);
    end else if (pick < 77) begin
      // extended frame: small sizes mostly, the full store and oversize rarely
      hdr[7:6] = 2'($urandom_range(3));
      hdr[2:0] = 3'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 85) hdr[5:3] = 3'($urandom_range(4));
      else if (pick < 96) hdr[5:3] = 3'd5;
      else hdr[5:3] = 3'($urandom_range(7, 6));
      frame_len = 32'd1 << hdr[5:3];
      chk = CHECK_SEED ^ hdr;
      send_word(1'b0, EXT_CODE);
      send_word(1'b0, 8'h00);
      send_word(1'b0, EXT_MARK);
      send_word(1'b0, hdr);
      for (int i = 0; i < int'(frame_len); i++) begin
        case ($urandom_range(29))
          0:       d = NACK_CODE;
          1:       d = SELECT_CODE;
          2:       d = EXT_CODE;
          default: d = 8'($urandom_range(255));
        endcase
        // a stray tick can trip the heartbeat and abort the frame
        if ($urandom_range(49) == 0) send_word(1'b1, 8'($urandom_range(255)));
        send_word(1'b0, d);
        chk = chk ^ d;
      end
      if ($urandom_range(7) == 0) chk = chk ^ 8'($urandom_range(255, 1));
      send_word(1'b0, chk);
    end else if (pick < 88) begin
      repeat ($urandom_range(4, 1)) send_word(1'b1, 8'($urandom_range(255)));
    end else begin
      case ($urandom_range(3))
        0: begin
          // broken prefix: nonzero second byte, one more byte swallowed
          send_word(1'b0, EXT_CODE);
          send_word(1'b0, 8'($urandom_range(255, 1)));
          send_word(1'b0, 8'($urandom_range(255)));
        end
        1: begin
          // broken prefix: wrong marker
          send_word(1'b0, EXT_CODE);
          send_word(1'b0, 8'h00);
          send_word(1'b0, EXT_MARK ^ 8'($urandom_range(255, 1)));
        end
        default: send_word(1'b0, 8'($urandom_range(255)));
      endcase
    end
  endtask

  // Result side: check each accepted word, then pick the next ready value
  initial begin
    int           hold_left;
    host_result_t got;
    host_result_t want;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got.kind  = res_ch.kind;
        got.data  = res_ch.data_byte;
        got.pmode = res_ch.payload_mode;
        got.last  = res_ch.last;
        got.amode = res_ch.active_mode;
        results_seen++;
        kind_seen[got.kind]++;
        if (due_results.size() == 0) begin
          note_mismatch($sformatf("result with nothing due: kind %0d data %02h",
                                  got.kind, got.data));
        end else begin
          want = due_results.pop_front();
          if (got != want)
            note_mismatch($sformatf({"result %0d: got kind %0d data %02h mode %0d last %0b",
                                     " active %0d, want kind %0d data %02h mode %0d",
                                     " last %0b active %0d"},
                                    results_seen, got.kind, got.data, got.pmode, got.last,
                                    got.amode, want.kind, want.data, want.pmode, want.last,
                                    want.amode));
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when no channel moves a word for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((host_ch.valid && host_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: %0d cycles without a handshake", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus
  initial begin
    script_row_t  row;
    host_result_t want;
    logic [3:0]   mc;
    byte_t        mask;
    cfg_data_t    hb;
    int           start;

    rst             <= 1'b1;
    host_ch.valid   <= 1'b0;
    host_ch.command <= 1'b0;
    host_ch.rx_byte <= 8'h00;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_MODE_COUNT;
    cfg_ch.data     <= '0;
    foreach (payload_r[i]) payload_r[i] = 8'h00;

    // Directed script, first under the reset settings: one mode, no delivery
    row_typed(1'b0, NACK_CODE, 2'd3, KIND_REPLY, 8'h44, 8'h00, 8'hBB, 3'd0, 3'd0);
    row_pred(1'b0, SELECT_CODE);    // mode 1 is not below the mode count
    row_pred(1'b0, 8'h01);
    row_pred(1'b0, 8'hBD);
    row_pred(1'b1, 8'hFF);
    row_pred(1'b0, EXT_CODE);       // one-byte frame with a bad checksum
    row_pred(1'b0, 8'h00);
    row_pred(1'b0, EXT_MARK);
    row_pred(1'b0, 8'h00);
    row_pred(1'b0, 8'hFF);
    row_typed(1'b0, 8'h12, 2'd1, KIND_ERROR, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0);
    row        = '0;
    row.is_cfg = 1'b1;
    row.mc     = 4'd8;
    row.mask   = 8'hFF;
    row.hb     = 32'd3;
    script.push_back(row);
    row_pred(1'b0, SELECT_CODE);    // top mode
    row_pred(1'b0, 8'h07);
    row_pred(1'b0, 8'hBB);
    row_typed(1'b0, NACK_CODE, 2'd3, KIND_REPLY, 8'h47, 8'h00, 8'hB8, 3'd0, 3'd7);
    row_pred(1'b0, EXT_CODE);       // two data-flagged bytes for mode 1
    row_pred(1'b0, 8'h00);
    row_pred(1'b0, EXT_MARK);
    row_pred(1'b0, 8'hC9);
    row_pred(1'b0, 8'h00);
    row_pred(1'b0, 8'hFF);
    row_pred(1'b0, 8'hC9);
    row_pred(1'b1, 8'h00);          // heartbeat fires on the fourth tick
    row_pred(1'b1, 8'h00);
    row_pred(1'b1, 8'h00);
    row_typed(1'b1, 8'h00, 2'd1, KIND_RESET, 8'h00, 8'h00, 8'h00, 3'd0, 3'd7);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Walk the script
    foreach (script[s]) begin
      row = script[s];
      if (row.is_cfg) begin
        drain();
        write_config(row.mc, row.mask, row.hb);
      end else begin
        send_word(row.cmd, row.b, !row.typed);
        if (row.typed) begin
          for (int k = 0; k < int'(row.n); k++) begin
            want.kind  = row.kind;
            want.data  = (k == 0) ? row.d0 : (k == 1) ? row.d1 : row.d2;
            want.pmode = row.pmode;
            want.last  = (k == int'(row.n) - 1);
            want.amode = row.amode;
            due_results.push_back(want);
          end
        end
      end
    end

    // Random phases, each under its own register setting, idling patterns set per pair of phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          mc = 4'd8;
          mask = 8'hFF;
          hb = 32'hFFFF_FFFF;
        end
        1: begin
          mc = 4'd1;
          mask = 8'h00;
          hb = 32'd1;
        end
        2: begin
          mc = 4'($urandom_range(8, 1));
          mask = 8'($urandom_range(255));
          hb = 32'($urandom_range(40, 2));
        end
        3: begin
          mc = 4'd8;
          mask = 8'($urandom_range(255));
          hb = 32'd5;
        end
        4: begin
          mc = 4'($urandom_range(8, 1));
          mask = 8'hFF;
          hb = 32'($urandom_range(40, 2));
        end
        default: begin
          mc = 4'($urandom_range(8, 1));
          mask = 8'($urandom_range(255));
          hb = 32'($urandom_range(40, 1));
        end
      endcase
      drain();
      write_config(mc, mask, hb);
      if (ph < 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 54;
      end else if (ph < 4) begin
        send_idle_pct = 54;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long result stall while words keep coming, so the input backs up
      if (ph == 0) hold_req = 1'b1;
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) send_host_message();
    end

    drain();
    $display("Run covered %0d host words under %0d register settings, %0d results checked.",
             words_sent, cfg_writes + 1, results_seen);
    $display("Results: %0d reply, %0d payload, %0d error, %0d reset; %0d mismatches.",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
